### src/fea_pkg.sv
// ----------------------------------------------------------------------------
// fea_pkg: flash extent allocator shared types
// Beat formats, status codes and sequencer states.
// ----------------------------------------------------------------------------
package fea_pkg;

    localparam int LEN_W = 30;
    localparam int SUB_SHIFT = 12;
    localparam int SUBSECTOR_BYTES = 32'h1000;
    localparam int HEADER_BYTES = 32'h100;
    localparam int TAG_W = 8;
    localparam int TAG_COUNT = 256;
    localparam logic [23:0] FIELD24_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_ID    = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_LEN,
        S_DECIDE,
        S_SCAN,
        S_LASTCHK,
        S_TAGS,
        S_PICK,
        S_SHIFT_UP,
        S_PLACE,
        S_FIND,
        S_SHIFT_DN,
        S_DONE
    } state_t;

    typedef struct packed {
        action_t     action;
        logic [11:0] pixel_count;
        logic [15:0] frame_count;
        logic [7:0]  free_id;
    } fea_in_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  assigned_id;
        logic [23:0] start_address;
        logic [23:0] extent_length;
        logic [6:0]  entries_in_use;
    } fea_out_t;

endpackage

### src/fea_ram.sv
// ----------------------------------------------------------------------------
// fea_ram: extent table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fea_ram #(
    parameter int DATA_W = 62,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### src/flash_extent_allocator_top.sv
// ----------------------------------------------------------------------------
// flash_extent_allocator_top: first-fit flash extent allocator
// Address-sorted extent table with allocate and free commands.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one command beat: allocate
//   (pixels * frames * 3 + 256 bytes, first fit on 4 KiB boundaries) or free
//   by id. out channel (out_valid/out_ready/out_data) returns one beat per
//   command. cfg channel writes total_subsectors and is always ready; it
//   must be written only while idle; the block itself does not enforce it.
//   One command is in flight at a time; in_ready is high only when idle.
//   Allocate and free times grow with the number of entries in the table,
//   as set by the one read port of the table RAM, which streams one entry
//   per cycle through the scan, id collection and shift passes.
//   The result waits in an output register; a stalled receiver holds the
//   next command in its final state until the register frees up.
//   Reset empties the table (count to zero) and sets total_subsectors to
//   4096; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module flash_extent_allocator_top #(
    parameter int MAX_ENTRIES = 64,
    parameter int ADDR_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fea_pkg::fea_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output fea_pkg::fea_out_t out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [12:0]      cfg_data
);

    import fea_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = TAG_W + ADDR_BITS + LEN_W;
    localparam int CALC_W = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 3;

    state_t             state_reg;
    state_t             state_next;
    logic [12:0]        cfg_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic               iss_reg;
    logic               dv_reg;
    logic [IDX_W-1:0]   dpos_reg;
    fea_in_t            item_reg;
    logic [27:0]        prod_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [CALC_W-1:0]  first_reg;
    logic [ADDR_BITS-1:0] where_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   cand_reg;
    logic [TAG_COUNT-1:0] bitmap_reg;
    status_t            status_reg;
    fea_out_t           res_reg;
    logic               out_valid_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENT_W-1:0]   wr_data;
    logic [ENT_W-1:0]   rd_data;

    logic [TAG_W-1:0]     rd_tag;
    logic [ADDR_BITS-1:0] rd_start;
    logic [LEN_W-1:0]     rd_size;
    logic [CALC_W-1:0]    start_ext;
    logic [CALC_W-1:0]    len_ext;
    logic [CALC_W-1:0]    end_sum;
    logic [CALC_W-1:0]    boundary;
    logic [CALC_W-1:0]    limit;
    logic [CALC_W-1:0]    flash_bytes;
    logic [CALC_W-1:0]    cap;
    logic [IDX_W-1:0]     last_idx;
    logic                 gap_hit;
    logic                 last_fits;
    logic                 tag_hit;
    logic                 is_alloc;
    logic                 table_full;
    logic [CNT_W-1:0]     dpos_plus;

    fea_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (MAX_ENTRIES)
    ) u_fea_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign rd_tag    = rd_data[ENT_W-1 -: TAG_W];
    assign rd_start  = rd_data[LEN_W +: ADDR_BITS];
    assign rd_size   = rd_data[LEN_W-1:0];
    assign start_ext = CALC_W'(rd_start);
    assign len_ext   = CALC_W'(len_reg);
    assign end_sum   = start_ext + CALC_W'(rd_size);
    assign boundary  = {end_sum[CALC_W-1:SUB_SHIFT], SUB_SHIFT'(0)}
                       + CALC_W'(SUBSECTOR_BYTES);
    assign flash_bytes = CALC_W'({cfg_reg, SUB_SHIFT'(0)});
    assign cap       = CALC_W'(1) << ADDR_BITS;
    assign limit     = (flash_bytes > cap) ? cap : flash_bytes;
    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign gap_hit   = (start_ext > first_reg) && ((start_ext - first_reg) > len_ext);
    assign last_fits = (first_reg + len_ext) < limit;
    assign tag_hit   = (rd_tag == item_reg.free_id);
    assign is_alloc  = (item_reg.action == ACT_ALLOC);
    assign table_full = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign dpos_plus = CNT_W'(dpos_reg) + CNT_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (is_alloc)
                begin
                    state_next = S_LEN;
                end
                else if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIND;
                end
            end
            S_LEN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (table_full)
                begin
                    state_next = S_DONE;
                end
                else if (count_reg == '0)
                begin
                    state_next = (len_ext < limit) ? S_PICK : S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dv_reg)
                begin
                    if ((dpos_reg != '0) && gap_hit)
                    begin
                        state_next = S_TAGS;
                    end
                    else if (dpos_reg == last_idx)
                    begin
                        state_next = S_LASTCHK;
                    end
                end
            end
            S_LASTCHK:
            begin
                state_next = last_fits ? S_TAGS : S_DONE;
            end
            S_TAGS:
            begin
                if (dv_reg && (dpos_reg == last_idx))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!bitmap_reg[cand_reg])
                begin
                    state_next = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP:
            begin
                if (!iss_reg && !dv_reg)
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                state_next = S_DONE;
            end
            S_FIND:
            begin
                if (dv_reg)
                begin
                    if (tag_hit)
                    begin
                        state_next = S_SHIFT_DN;
                    end
                    else if (dpos_reg == last_idx)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT_DN:
            begin
                if (!iss_reg && !dv_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and table write port
    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        wr_en    = 1'b0;
        wr_addr  = dpos_reg;
        wr_data  = rd_data;
        unique case (state_reg)
            S_SHIFT_UP:
            begin
                wr_en   = dv_reg;
                wr_addr = dpos_reg + IDX_W'(1);
            end
            S_SHIFT_DN:
            begin
                wr_en   = dv_reg;
                wr_addr = dpos_reg - IDX_W'(1);
            end
            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(pos_reg);
                wr_data = {tag_reg, where_reg, len_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= 13'd4096;
            count_reg     <= '0;
            iss_reg       <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= 1'b0;
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                    end
                end
                S_MUL:
                begin
                    prod_reg   <= 28'(item_reg.pixel_count) * 28'(item_reg.frame_count);
                    status_reg <= ST_OK;
                    ptr_reg    <= '0;
                    iss_reg    <= 1'b1;
                    if (!is_alloc && (count_reg == '0))
                    begin
                        status_reg <= ST_NO_ID;
                    end
                end
                S_LEN:
                begin
                    len_reg <= LEN_W'(prod_reg) + LEN_W'({prod_reg, 1'b0})
                               + LEN_W'(HEADER_BYTES);
                end
                S_DECIDE:
                begin
                    bitmap_reg <= '0;
                    cand_reg   <= TAG_W'(1);
                    ptr_reg    <= '0;
                    iss_reg    <= 1'b1;
                    where_reg  <= '0;
                    pos_reg    <= '0;
                    if (table_full)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else if ((count_reg == '0) && !(len_ext < limit))
                    begin
                        status_reg <= ST_NO_SPACE;
                    end
                end
                S_SCAN, S_TAGS, S_FIND, S_SHIFT_DN:
                begin
                    // stream entries upward, one read per cycle
                    if (iss_reg)
                    begin
                        ptr_reg <= ptr_reg + IDX_W'(1);
                        iss_reg <= (ptr_reg != last_idx);
                    end
                    dv_reg   <= iss_reg;
                    dpos_reg <= ptr_reg;
                    if ((state_reg == S_SCAN) && dv_reg)
                    begin
                        if ((dpos_reg != '0) && gap_hit)
                        begin
                            where_reg <= ADDR_BITS'(first_reg);
                            pos_reg   <= CNT_W'(dpos_reg);
                            ptr_reg   <= '0;
                            iss_reg   <= 1'b1;
                            dv_reg    <= 1'b0;
                        end
                        else
                        begin
                            first_reg <= boundary;
                        end
                    end
                    if ((state_reg == S_TAGS) && dv_reg)
                    begin
                        bitmap_reg[rd_tag] <= 1'b1;
                    end
                    if ((state_reg == S_FIND) && dv_reg)
                    begin
                        if (tag_hit)
                        begin
                            ptr_reg <= IDX_W'(dpos_plus);
                            iss_reg <= (dpos_plus < count_reg);
                            dv_reg  <= 1'b0;
                        end
                        else if (dpos_reg == last_idx)
                        begin
                            status_reg <= ST_NO_ID;
                        end
                    end
                    if ((state_reg == S_SHIFT_DN) && !iss_reg && !dv_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                S_LASTCHK:
                begin
                    ptr_reg <= '0;
                    iss_reg <= 1'b1;
                    if (last_fits)
                    begin
                        where_reg <= ADDR_BITS'(first_reg);
                        pos_reg   <= count_reg;
                    end
                    else
                    begin
                        status_reg <= ST_NO_SPACE;
                    end
                end
                S_PICK:
                begin
                    if (bitmap_reg[cand_reg])
                    begin
                        cand_reg <= cand_reg + TAG_W'(1);
                    end
                    else
                    begin
                        tag_reg <= cand_reg;
                        ptr_reg <= last_idx;
                        iss_reg <= (pos_reg != count_reg);
                    end
                end
                S_SHIFT_UP:
                begin
                    // move entries up one slot, top first
                    if (iss_reg)
                    begin
                        ptr_reg <= ptr_reg - IDX_W'(1);
                        iss_reg <= (ptr_reg != IDX_W'(pos_reg));
                    end
                    dv_reg   <= iss_reg;
                    dpos_reg <= ptr_reg;
                end
                S_PLACE:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg          <= 1'b1;
                        res_reg.status         <= status_reg;
                        res_reg.entries_in_use <= 7'(count_reg);
                        res_reg.assigned_id    <= '0;
                        res_reg.start_address  <= '0;
                        res_reg.extent_length  <= '0;
                        if (is_alloc)
                        begin
                            res_reg.extent_length <= (len_reg > LEN_W'(FIELD24_MAX))
                                                     ? FIELD24_MAX : len_reg[23:0];
                            if (status_reg == ST_OK)
                            begin
                                res_reg.assigned_id   <= tag_reg;
                                res_reg.start_address <= 24'(where_reg);
                            end
                        end
                    end
                end
                default:
                begin
                    dv_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

### src/fea_checker.sv
// ----------------------------------------------------------------------------
// fea_checker: port-level checks for the flash extent allocator
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module fea_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input fea_pkg::fea_out_t out_data
);

    import fea_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    // drop ready after taking a command
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while one is in flight");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK)
        |-> (out_data.assigned_id == '0) && (out_data.start_address == '0))
        else $error("failed command reports an id or address");

    a_free_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OK) && (out_data.assigned_id == '0)
        |-> (out_data.extent_length == '0) && (out_data.start_address == '0))
        else $error("free result carries a length or address");

endmodule

bind flash_extent_allocator_top fea_checker u_fea_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: flash extent allocator testbench
// Drives allocate and free commands with random gaps and output stalls,
// predicts every result from a behavioral copy of the extent table, and
// compares each result beat field by field. Several flash sizes are used.
// ----------------------------------------------------------------------------
module tb_top;
    import fea_pkg::*;

    localparam int TBL_DEPTH = 64;
    localparam logic [32:0] ADDR_CAP = 33'h1000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    fea_in_t in_data;
    logic out_valid;
    logic out_ready;
    fea_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [12:0] cfg_data;

    flash_extent_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // model of the extent table
    logic [31:0] tbl_start [TBL_DEPTH];
    logic [31:0] tbl_len [TBL_DEPTH];
    logic [7:0] tbl_tag [TBL_DEPTH];
    int tbl_count;
    logic [12:0] subsectors;

    fea_in_t cmd_q[$];
    fea_out_t result_q[$];
    int errors;
    int sent;
    bit gaps_on;
    int stall_hold;
    bit pause_in;

    function automatic fea_out_t predict_command(fea_in_t c);
        fea_out_t r;
        logic [32:0] lim;
        logic [32:0] first;
        logic [32:0] nxt;
        logic [32:0] gap;
        logic [32:0] where;
        logic [31:0] len;
        int pos;
        int k;
        int j;
        bit found;
        bit taken;
        logic [7:0] tag;
        r = '0;
        where = '0;
        pos = 0;
        found = 0;
        tag = '0;
        if (c.action == ACT_ALLOC) begin
            len = c.pixel_count * c.frame_count * 3 + 32'h100;
            lim = {20'd0, subsectors} << 12;
            if (lim > ADDR_CAP) lim = ADDR_CAP;
            r.extent_length = (len > 32'hFFFFFF) ? 24'hFFFFFF : len[23:0];
            if (tbl_count >= TBL_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (tbl_count == 0) begin
                    if ({1'b0, len} < lim) found = 1;
                end else begin
                    for (k = 0; k < tbl_count; k++) begin
                        first = (({1'b0, tbl_start[k]} + tbl_len[k]) & ~33'hFFF) + 33'h1000;
                        if (k == tbl_count - 1) begin
                            if (first + len < lim) begin
                                found = 1;
                                where = first;
                                pos = k + 1;
                            end
                            break;
                        end
                        nxt = {1'b0, tbl_start[k + 1]};
                        gap = (nxt > first) ? nxt - first : '0;
                        if (gap > len) begin
                            found = 1;
                            where = first;
                            pos = k + 1;
                            break;
                        end
                    end
                end
                if (!found) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    for (j = 1; j < 256; j++) begin
                        taken = 0;
                        for (k = 0; k < tbl_count; k++)
                            if (tbl_tag[k] == j) taken = 1;
                        if (!taken) begin
                            tag = 8'(j);
                            break;
                        end
                    end
                    for (k = tbl_count; k > pos; k--) begin
                        tbl_start[k] = tbl_start[k - 1];
                        tbl_len[k] = tbl_len[k - 1];
                        tbl_tag[k] = tbl_tag[k - 1];
                    end
                    tbl_start[pos] = where[31:0];
                    tbl_len[pos] = len;
                    tbl_tag[pos] = tag;
                    tbl_count++;
                    r.status = ST_OK;
                    r.assigned_id = tag;
                    r.start_address = where[23:0];
                end
            end
        end else begin
            for (k = 0; k < tbl_count; k++)
                if (tbl_tag[k] == c.free_id) begin
                    found = 1;
                    break;
                end
            if (!found) begin
                r.status = ST_NO_ID;
            end else begin
                for (; k + 1 < tbl_count; k++) begin
                    tbl_start[k] = tbl_start[k + 1];
                    tbl_len[k] = tbl_len[k + 1];
                    tbl_tag[k] = tbl_tag[k + 1];
                end
                tbl_count--;
                r.status = ST_OK;
            end
        end
        r.entries_in_use = tbl_count[6:0];
        return r;
    endfunction

    function automatic fea_in_t alloc_cmd(logic [11:0] px, logic [15:0] fr);
        fea_in_t c;
        c = '0;
        c.action = ACT_ALLOC;
        c.pixel_count = px;
        c.frame_count = fr;
        c.free_id = 8'($urandom);
        return c;
    endfunction

    function automatic fea_in_t free_cmd(logic [7:0] id);
        fea_in_t c;
        c.action = ACT_FREE;
        c.pixel_count = 12'($urandom);
        c.frame_count = 16'($urandom);
        c.free_id = id;
        return c;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // driver
    int idle_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 0;
            in_data <= '0;
            idle_left = 0;
        end else begin
            if (in_valid && in_ready) begin
                result_q.push_back(predict_command(in_data));
                sent++;
            end
            if (!in_valid || in_ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    in_valid <= 0;
                end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                    idle_left = $urandom_range(0, 4);
                    in_valid <= 0;
                end else if (cmd_q.size() > 0 && !pause_in) begin
                    in_data <= cmd_q.pop_front();
                    in_valid <= 1;
                end else begin
                    in_valid <= 0;
                end
            end
        end
    end

    // monitor and output stall
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%t: unexpected result beat %p", $time, out_data);
                    errors++;
                end else begin
                    fea_out_t e;
                    e = result_q.pop_front();
                    if (out_data.status !== e.status)
                        $display("%t: status exp %0d got %0d", $time, e.status,
                                 out_data.status);
                    if (out_data.assigned_id !== e.assigned_id)
                        $display("%t: assigned_id exp %0d got %0d", $time,
                                 e.assigned_id, out_data.assigned_id);
                    if (out_data.start_address !== e.start_address)
                        $display("%t: start_address exp %h got %h", $time,
                                 e.start_address, out_data.start_address);
                    if (out_data.extent_length !== e.extent_length)
                        $display("%t: extent_length exp %h got %h", $time,
                                 e.extent_length, out_data.extent_length);
                    if (out_data.entries_in_use !== e.entries_in_use)
                        $display("%t: entries_in_use exp %0d got %0d", $time,
                                 e.entries_in_use, out_data.entries_in_use);
                    if (out_data !== e) errors++;
                end
            end
            if (stall_hold > 0) begin
                stall_hold--;
                out_ready <= 0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 0;
            end else begin
                out_ready <= 1;
            end
        end
    end

    task automatic drain();
        while (cmd_q.size() > 0 || in_valid || result_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_subsectors(logic [12:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        subsectors = v;
    endtask

    // random mix: half allocations, mostly small sizes; half frees, mostly of ids 1 to 70
    task automatic random_phase(int count);
        fea_in_t c;
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                if ($urandom_range(0, 9) == 0)
                    c = alloc_cmd(12'($urandom), 16'($urandom));
                else
                    c = alloc_cmd(12'($urandom_range(0, 300)),
                                  16'($urandom_range(0, 40)));
            end else if (kind < 90) begin
                c = free_cmd(8'($urandom_range(1, 70)));
            end else begin
                c = free_cmd(8'($urandom));
            end
            cmd_q.push_back(c);
        end
    endtask

    initial
    begin
        errors = 0;
        sent = 0;
        gaps_on = 1;
        stall_hold = 0;
        pause_in = 0;
        tbl_count = 0;
        subsectors = 13'd4096;
        cfg_valid = 0;
        cfg_data = '0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: empty table, field extremes, frees, full table
        cmd_q.push_back(free_cmd(8'd0));
        cmd_q.push_back(alloc_cmd(12'd0, 16'd0));
        cmd_q.push_back(alloc_cmd(12'hFFF, 16'hFFFF));
        cmd_q.push_back(alloc_cmd(12'd100, 16'd10));
        cmd_q.push_back(alloc_cmd(12'd1, 16'd1));
        cmd_q.push_back(free_cmd(8'd2));
        cmd_q.push_back(alloc_cmd(12'd5, 16'd5));
        cmd_q.push_back(free_cmd(8'd1));
        cmd_q.push_back(free_cmd(8'hFF));
        cmd_q.push_back(alloc_cmd(12'd0, 16'd0));
        cmd_q.push_back(alloc_cmd(12'd2000, 16'd2000));
        for (int i = 0; i < 66; i++) cmd_q.push_back(alloc_cmd(12'd0, 16'd0));
        drain();
        // hold off output while input keeps coming
        for (int i = 0; i < 20; i++) cmd_q.push_back(free_cmd(8'(i)));
        stall_hold = 400;
        drain();
        for (int i = 0; i < 70; i++) cmd_q.push_back(free_cmd(8'(i)));
        drain();

        write_subsectors(13'd0);
        cmd_q.push_back(alloc_cmd(12'd0, 16'd0));
        cmd_q.push_back(alloc_cmd(12'hFFF, 16'd1));
        drain();
        write_subsectors(13'h1FFF);
        random_phase(400);
        drain();
        write_subsectors(13'd1);
        cmd_q.push_back(alloc_cmd(12'd1, 16'd1));
        cmd_q.push_back(alloc_cmd(12'd1, 16'd1));
        random_phase(150);
        drain();
        write_subsectors(13'd40);
        random_phase(400);
        // sender waits for all results
        pause_in = 1;
        while (result_q.size() > 0 || in_valid) @(posedge clk);
        pause_in = 0;
        drain();
        write_subsectors(13'd4096);
        random_phase(350);
        drain();
        gaps_on = 0;
        write_subsectors(13'd300);
        random_phase(250);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
